### rtl/scq_pkg.sv
// ----------------------------------------------------------------------------
// scq_pkg
// Shared constants and keymaps for the scancode queue translator.
// ----------------------------------------------------------------------------
package scq_pkg;

  typedef enum logic [0:0] {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef logic [7:0] byte_t;

  // set-1 codes with special handling
  localparam byte_t SC_CTRL        = 8'h1D;
  localparam byte_t SC_LSHIFT      = 8'h2A;
  localparam byte_t SC_RSHIFT      = 8'h36;
  localparam byte_t SC_ALT         = 8'h38;
  localparam byte_t SC_CAPS        = 8'h3A;
  localparam byte_t SC_LSHIFT_BRK  = 8'hAA;
  localparam byte_t SC_RSHIFT_BRK  = 8'hB6;

  localparam int unsigned MAP_SIZE = 60;

  localparam byte_t MAP_PLAIN [0:MAP_SIZE-1] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'hBF,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'hAE, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'hAF, 8'h2A, 8'h8E, 8'h20, 8'hB8, 8'h0C
  };

  localparam byte_t MAP_SHIFTED [0:MAP_SIZE-1] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'hBF,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'hAE, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'hAF, 8'h2A, 8'h8E, 8'h20, 8'hB8, 8'h0C
  };

  localparam byte_t MAP_CAPITAL [0:MAP_SIZE-1] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h5B, 8'h5D, 8'h0A, 8'hBF,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3B,
    8'h27, 8'h60, 8'hAE, 8'h5C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h2C, 8'h2E, 8'h2F, 8'hAF, 8'h2A, 8'h8E, 8'h20, 8'hB8, 8'h0C
  };

endpackage

### rtl/scq_if.sv
// ----------------------------------------------------------------------------
// scq_in_if / scq_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface scq_in_if;
  logic       valid;
  logic       ready;
  logic [0:0] cmd;
  logic [7:0] scan_byte;

  modport source (output valid, output cmd, output scan_byte, input ready);
  modport sink   (input valid, input cmd, input scan_byte, output ready);
endinterface

interface scq_out_if;
  logic       valid;
  logic       ready;
  logic       push_taken;
  logic       queue_was_empty;
  logic       char_valid;
  logic [7:0] char_code;
  logic       shift_on;
  logic       caps_on;

  modport source (output valid, output push_taken, output queue_was_empty,
                  output char_valid, output char_code, output shift_on,
                  output caps_on, input ready);
  modport sink   (input valid, input push_taken, input queue_was_empty,
                  input char_valid, input char_code, input shift_on,
                  input caps_on, output ready);
endinterface

### rtl/scq_ram.sv
// ----------------------------------------------------------------------------
// scq_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module scq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/scancode_queue_ascii_translator.sv
// ----------------------------------------------------------------------------
// scancode_queue_ascii_translator
// A command beat passes the queue RAM read, then the output register.
//   Throughput: one beat per cycle while results are taken, limited by the
//   single RAM write and read ports, one command using at most one each.
// Reset (rst, synchronous): pointers, shift and caps state and all valid
//   flags clear at once; queue RAM contents are not cleared. Command ready
//   is held low while rst is high.
// ----------------------------------------------------------------------------
module scancode_queue_ascii_translator #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  scq_in_if.sink           items,
  scq_out_if.source        results
);
  import scq_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

  // --------------------------------------------------------------------------
  // Pointers, live at the accept stage. A pop can only read a slot that was
  // written on an earlier cycle, so the RAM needs no bypass.
  // --------------------------------------------------------------------------
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW-1:0] wr_ptr_inc, rd_ptr_inc;
  logic          accept, is_pop, q_empty, q_full;
  logic          do_push, do_pop;

  assign wr_ptr_inc = (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_inc = (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
  assign q_empty    = (wr_ptr == rd_ptr);
  assign q_full     = (wr_ptr_inc == rd_ptr);   // one slot kept free

  assign accept  = items.valid && items.ready;
  assign is_pop  = (cmd_t'(items.cmd) == CMD_POP);
  assign do_push = accept && !is_pop && !q_full;
  assign do_pop  = accept && is_pop && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr_inc;
      if (do_pop)  rd_ptr <= rd_ptr_inc;
    end
  end

  // --------------------------------------------------------------------------
  // Queue storage
  // --------------------------------------------------------------------------
  byte_t rd_data;

  scq_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (do_push),
    .waddr (wr_ptr),
    .wdata (items.scan_byte),
    .re    (do_pop),
    .raddr (rd_ptr),
    .rdata (rd_data)
  );

  // --------------------------------------------------------------------------
  // Stage 1: beat waits for RAM data. The RAM output only reloads on a new
  // pop, so it holds while this stage is stalled.
  // --------------------------------------------------------------------------
  logic s1_valid, s1_pop, s1_empty, s1_taken;
  logic advance;

  assign advance     = !results.valid || results.ready;
  assign items.ready = !rst && (!s1_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pop   <= is_pop;
      s1_empty <= is_pop && q_empty;
      s1_taken <= do_push;
    end
  end

  // --------------------------------------------------------------------------
  // Retire: modifier update and keymap lookup, state written back on the
  // cycle the beat moves into the output register.
  // --------------------------------------------------------------------------
  logic  shift_held, caps_locked;
  logic  shift_next, caps_next;
  logic  hit, translate;
  byte_t char_next;
  logic [5:0] map_idx;

  assign hit     = s1_pop && !s1_empty;
  assign map_idx = rd_data[5:0];

  always_comb begin
    shift_next = shift_held;
    caps_next  = caps_locked;
    if (hit) begin
      if (rd_data == SC_LSHIFT || rd_data == SC_RSHIFT) begin
        shift_next = 1'b1;
      end else if (rd_data == SC_LSHIFT_BRK || rd_data == SC_RSHIFT_BRK) begin
        shift_next = 1'b0;
      end
      if (rd_data == SC_CAPS) begin
        caps_next = !caps_locked;
      end
    end
  end

  // modifiers and codes past the map give no character
  assign translate = hit && (rd_data < 8'(MAP_SIZE)) &&
                     rd_data != SC_CTRL && rd_data != SC_LSHIFT &&
                     rd_data != SC_RSHIFT && rd_data != SC_ALT &&
                     rd_data != SC_CAPS;

  // caps and shift together fall back to the plain map
  always_comb begin
    char_next = '0;
    if (translate) begin
      if (caps_next && !shift_next) begin
        char_next = MAP_CAPITAL[map_idx];
      end else if (shift_next && !caps_next) begin
        char_next = MAP_SHIFTED[map_idx];
      end else begin
        char_next = MAP_PLAIN[map_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held    <= 1'b0;
      caps_locked   <= 1'b0;
      results.valid <= 1'b0;
    end else if (advance) begin
      results.valid <= s1_valid;
      if (s1_valid) begin
        shift_held  <= shift_next;
        caps_locked <= caps_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      results.push_taken      <= s1_taken;
      results.queue_was_empty <= s1_empty;
      results.char_valid      <= translate;
      results.char_code       <= char_next;
      results.shift_on        <= shift_next;
      results.caps_on         <= caps_next;
    end
  end

endmodule

### sim/scancode_queue_ascii_translator_tb.sv
// ----------------------------------------------------------------------------
// scancode_queue_ascii_translator_tb
// Self-checking bench for the scancode queue translator. A short directed
// run and a long random run of push/pop beats go in on the command channel.
// A scoreboard copy of the code queue and the shift/caps state predicts each
// result beat, and every result is checked field by field. Both channels
// idle at random.
// ----------------------------------------------------------------------------
module scancode_queue_ascii_translator_tb;
  import scq_pkg::*;

  localparam int unsigned QDEPTH       = 64;
  localparam int unsigned QW           = $clog2(QDEPTH);
  localparam int unsigned KEYMAP_LEN   = 60;
  localparam int unsigned KW           = $clog2(KEYMAP_LEN);
  localparam int unsigned RANDOM_BEATS = 1825;
  // No beat for this long means the block hung. The slowest correct gap is
  // a sender gap plus a receiver stall plus the pipeline.
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned TAIL_CYCLES  = 10;

  // Scoreboard keymaps; caps characters are the plain map with letters raised.
  localparam logic [7:0] KEY_PLAIN [0:KEYMAP_LEN-1] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'hBF,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'hAE, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'hAF, 8'h2A, 8'h8E, 8'h20, 8'hB8, 8'h0C
  };

  localparam logic [7:0] KEY_SHIFTED [0:KEYMAP_LEN-1] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'hBF,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'hAE, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'hAF, 8'h2A, 8'h8E, 8'h20, 8'hB8, 8'h0C
  };

  // One planned command beat: payload, idle cycles before it, and whether
  // the sender must first wait for every outstanding result.
  typedef struct {
    cmd_t        cmd;
    byte_t       scan;
    int unsigned gap;
    bit          drain;
  } key_beat_t;

  typedef struct packed {
    logic       push_taken;
    logic       queue_was_empty;
    logic       char_valid;
    logic [7:0] char_code;
    logic       shift_on;
    logic       caps_on;
  } key_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  scq_in_if  cmd_ch ();
  scq_out_if res_ch ();

  scancode_queue_ascii_translator #(
    .QUEUE_DEPTH (QDEPTH)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (cmd_ch),
    .results (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  key_beat_t   keystroke_plan [$];
  key_result_t expected_results [$];

  // scoreboard copy of the block state
  byte_t       model_fifo [QDEPTH];
  int unsigned model_wr    = 0;
  int unsigned model_rd    = 0;
  bit          model_shift = 1'b0;
  bit          model_caps  = 1'b0;

  // handshakes seen at the last rising edge, for the falling-edge drivers
  logic        in_fire  = 1'b0;
  logic        out_fire = 1'b0;

  int unsigned errors = 0;
  int unsigned beats_in = 0;
  int unsigned n_stored = 0, n_dropped = 0, n_empty = 0;
  int unsigned n_plain = 0, n_shifted = 0, n_caps = 0, n_untranslated = 0;
  int unsigned idle_cycles = 0;

  // sender/receiver pacing state, touched only by their own always blocks
  int unsigned tx_hold  = 0;
  bit          tx_armed = 1'b0;
  int unsigned rx_stall = 0;
  bit          rx_calm  = 1'b0;

  function automatic logic [7:0] capital_of(byte_t sc);
    logic [7:0] b;
    b = KEY_PLAIN[sc[KW-1:0]];
    if (b >= 8'h61 && b <= 8'h7A) return b - 8'h20;
    return b;
  endfunction

  // Idle cycles before a beat: often none, sometimes short, sometimes long.
  function automatic int unsigned pick_wait(bit calm);
    if (calm) return 0;
    case ($urandom_range(0, 3))
      0: return 0;
      1: return $urandom_range(0, 2);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  // Mostly typing: keymap codes, shift make/break and caps, some ctrl/alt,
  // and a share of arbitrary bytes for release codes and unmapped keys.
  function automatic byte_t pick_scancode();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return byte_t'($urandom_range(0, KEYMAP_LEN - 1));
    if (roll < 55) return ($urandom_range(0, 1) != 0) ? SC_LSHIFT : SC_RSHIFT;
    if (roll < 65) return ($urandom_range(0, 1) != 0) ? SC_LSHIFT_BRK : SC_RSHIFT_BRK;
    if (roll < 73) return SC_CAPS;
    if (roll < 80) return ($urandom_range(0, 1) != 0) ? SC_CTRL : SC_ALT;
    return byte_t'($urandom_range(0, 255));
  endfunction

  task automatic add_beat(cmd_t cmd, byte_t scan, bit calm, bit drain);
    key_beat_t b;
    b.cmd   = cmd;
    b.scan  = scan;
    b.gap   = pick_wait(calm);
    b.drain = drain;
    keystroke_plan.push_back(b);
  endtask

  // Apply one accepted command beat to the scoreboard state and queue the
  // result it must produce.
  task automatic predict_keystroke(cmd_t cmd, byte_t scan);
    key_result_t r;
    byte_t       sc;
    r = '0;
    if (cmd == CMD_PUSH) begin
      // one slot always stays free, so the queue holds QDEPTH-1 codes
      if (((model_wr + 1) % QDEPTH) != model_rd) begin
        model_fifo[model_wr[QW-1:0]] = scan;
        model_wr = (model_wr + 1) % QDEPTH;
        r.push_taken = 1'b1;
        n_stored++;
      end else begin
        n_dropped++;
      end
    end else if (model_rd == model_wr) begin
      // empty pop leaves shift and caps alone
      r.queue_was_empty = 1'b1;
      n_empty++;
    end else begin
      sc = model_fifo[model_rd[QW-1:0]];
      model_rd = (model_rd + 1) % QDEPTH;
      if (sc == SC_LSHIFT || sc == SC_RSHIFT) model_shift = 1'b1;
      else if (sc == SC_LSHIFT_BRK || sc == SC_RSHIFT_BRK) model_shift = 1'b0;
      if (sc == SC_CAPS) model_caps = !model_caps;
      if (sc < KEYMAP_LEN && sc != SC_CTRL && sc != SC_LSHIFT && sc != SC_RSHIFT &&
          sc != SC_ALT && sc != SC_CAPS) begin
        r.char_valid = 1'b1;
        // caps with shift held falls back to the plain map
        if (model_caps && !model_shift) begin
          r.char_code = capital_of(sc);
          n_caps++;
        end else if (model_shift && !model_caps) begin
          r.char_code = KEY_SHIFTED[sc[KW-1:0]];
          n_shifted++;
        end else begin
          r.char_code = KEY_PLAIN[sc[KW-1:0]];
          n_plain++;
        end
      end else begin
        n_untranslated++;
      end
    end
    r.shift_on = model_shift;
    r.caps_on  = model_caps;
    expected_results.push_back(r);
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t  %s mismatch: expected 0x%02h, got 0x%02h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Rising edge: record handshakes, predict accepted commands, then check
  // accepted results against the oldest expectation.
  always @(posedge clk) begin
    key_result_t want;
    key_result_t got;
    if (rst) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= cmd_ch.valid && cmd_ch.ready;
      out_fire <= res_ch.valid && res_ch.ready;
      if (cmd_ch.valid && cmd_ch.ready) begin
        predict_keystroke(cmd_t'(cmd_ch.cmd), cmd_ch.scan_byte);
        beats_in++;
      end
      if (res_ch.valid && res_ch.ready) begin
        got = {res_ch.push_taken, res_ch.queue_was_empty, res_ch.char_valid,
               res_ch.char_code, res_ch.shift_on, res_ch.caps_on};
        if (expected_results.size() == 0) begin
          $display("%0t  unexpected result beat: expected none, got 0x%04h", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("push_taken", 8'(want.push_taken), 8'(got.push_taken));
          check_field("queue_was_empty", 8'(want.queue_was_empty),
                      8'(got.queue_was_empty));
          check_field("char_valid", 8'(want.char_valid), 8'(got.char_valid));
          check_field("char_code", want.char_code, got.char_code);
          check_field("shift_on", 8'(want.shift_on), 8'(got.shift_on));
          check_field("caps_on", 8'(want.caps_on), 8'(got.caps_on));
        end
      end
    end
  end

  // Command driver, falling edge. A beat leaves the bus once taken; the next
  // one goes up after its idle count, and a drain beat also waits until the
  // scoreboard has nothing outstanding. valid gets exactly one NBA per edge.
  always @(negedge clk) begin
    logic      nv;
    key_beat_t nxt;
    if (rst) begin
      cmd_ch.valid     <= 1'b0;
      cmd_ch.cmd       <= CMD_PUSH;
      cmd_ch.scan_byte <= 8'h00;
    end else begin
      nv = cmd_ch.valid;
      if (in_fire) nv = 1'b0;
      if (!nv && keystroke_plan.size() != 0) begin
        if (!tx_armed) begin
          tx_hold  = keystroke_plan[0].gap;
          tx_armed = 1'b1;
        end
        if (tx_hold != 0) begin
          tx_hold--;
        end else if (!(keystroke_plan[0].drain && expected_results.size() != 0)) begin
          nxt      = keystroke_plan.pop_front();
          tx_armed = 1'b0;
          nv       = 1'b1;
          cmd_ch.cmd       <= nxt.cmd;
          cmd_ch.scan_byte <= nxt.scan;
        end
      end
      cmd_ch.valid <= nv;
    end
  end

  // Result receiver, falling edge. A fresh stall is drawn after each taken
  // beat; now and then it switches between stalling and always ready.
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (out_fire) begin
        if ($urandom_range(0, 59) == 0) rx_calm = !rx_calm;
        rx_stall = pick_wait(rx_calm);
      end
      if (rx_stall != 0) begin
        rx_stall--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t  watchdog: no beat for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, expected_results.size());
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned planned;
    int unsigned seg_len;
    int unsigned push_pct;
    bit          calm;
    bit          drain;
    bit          first;
    byte_t       directed_codes [$];

    cmd_ch.valid     = 1'b0;
    cmd_ch.cmd       = CMD_PUSH;
    cmd_ch.scan_byte = 8'h00;
    res_ch.ready     = 1'b0;

    // Directed: pop on an empty queue, then codes for scancode zero, an
    // out-of-range byte, ctrl, alt, the last and first-past-end keymap
    // codes, a letter under shift, caps with shift held, and a digit under
    // caps alone after the shift break. Pushed as a batch, then popped.
    directed_codes = '{8'h00, 8'hFF, SC_CTRL, SC_ALT, 8'h3B, 8'h3C,
                       SC_LSHIFT, 8'h1E, SC_CAPS, 8'h1E, SC_RSHIFT_BRK, 8'h02};
    add_beat(CMD_POP, 8'h00, 1'b0, 1'b0);
    foreach (directed_codes[i]) add_beat(CMD_PUSH, directed_codes[i], 1'b0, 1'b0);
    foreach (directed_codes[i]) add_beat(CMD_POP, 8'hA5, 1'b0, 1'b0);

    // Random: segments that lean toward filling the queue (reaching the
    // full-queue drop), emptying it (empty pops) or a balanced mix. Some
    // segments run back to back with no idling; some open with a drain.
    planned = 0;
    first   = 1'b1;
    while (planned < RANDOM_BEATS) begin
      seg_len = $urandom_range(20, 150);
      case ($urandom_range(0, 2))
        0: push_pct = 90;
        1: push_pct = 10;
        default: push_pct = 55;
      endcase
      calm  = ($urandom_range(0, 3) == 0);
      drain = first || ($urandom_range(0, 5) == 0);
      first = 1'b0;
      for (int i = 0; i < seg_len && planned < RANDOM_BEATS; i++) begin
        if ($urandom_range(0, 99) < push_pct)
          add_beat(CMD_PUSH, pick_scancode(), calm, drain && i == 0);
        else
          add_beat(CMD_POP, byte_t'($urandom_range(0, 255)), calm, drain && i == 0);
        planned++;
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (keystroke_plan.size() != 0 || cmd_ch.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    // tail: catch any stray result beat after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d command beats: %0d codes queued, %0d pushes dropped on full, %0d empty pops",
             beats_in, n_stored, n_dropped, n_empty);
    $display("Popped %0d plain, %0d shifted, %0d caps chars and %0d untranslated codes; %0d errors",
             n_plain, n_shifted, n_caps, n_untranslated, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
